// File: rtl/rbsi_pkg.sv
package rbsi_pkg;

    // Coordinate format: signed fixed point with FRAC_BITS fraction bits.
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int AXES        = 3;
    localparam int DIVS        = 2 * AXES;

    // Numerator magnitude: |corner - origin| scaled by 2^FRAC_BITS.
    localparam int NUM_W = COORD_WIDTH + 1 + FRAC_BITS;
    // Divisor magnitude: |direction| fits in COORD_WIDTH unsigned bits.
    localparam int DEN_W = COORD_WIDTH;
    // Interval ends carry one extra bit for the unbounded marks.
    localparam int T_W   = COORD_WIDTH + 1;
    localparam int MD_W  = 17;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic        [NUM_W-1:0]       t_num;
    typedef logic        [DEN_W-1:0]       t_den;
    typedef logic signed [T_W-1:0]         t_tval;
    typedef logic        [MD_W-1:0]        t_mind;

    localparam t_mind  MD_RESET  = t_mind'(66);
    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_coord MISS_DIST = t_coord'(-(longint'(1) <<< FRAC_BITS));
    localparam t_tval  T_LO_UNB  = {1'b1, {COORD_WIDTH{1'b0}}};
    localparam t_tval  T_HI_UNB  = {1'b0, {COORD_WIDTH{1'b1}}};
    localparam t_num   SAT_POS   = {{(NUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam t_num   SAT_NEG   = t_num'(1) << (COORD_WIDTH - 1);

    // Per-item control that travels alongside the dividers.
    typedef struct packed {
        logic            valid;
        logic [DIVS-1:0] neg;
        logic [AXES-1:0] zero;
        logic [AXES-1:0] in_slab;
    } t_sb;

endpackage

// File: rtl/rbsi_if.sv
// Ray and box input channel.
interface rbsi_ray_if;
    logic                 valid;
    logic                 ready;
    rbsi_pkg::t_coord     origin_x;
    rbsi_pkg::t_coord     origin_y;
    rbsi_pkg::t_coord     origin_z;
    rbsi_pkg::t_coord     dir_x;
    rbsi_pkg::t_coord     dir_y;
    rbsi_pkg::t_coord     dir_z;
    rbsi_pkg::t_coord     lo_corner_x;
    rbsi_pkg::t_coord     lo_corner_y;
    rbsi_pkg::t_coord     lo_corner_z;
    rbsi_pkg::t_coord     hi_corner_x;
    rbsi_pkg::t_coord     hi_corner_y;
    rbsi_pkg::t_coord     hi_corner_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    lo_corner_x, lo_corner_y, lo_corner_z,
                    hi_corner_x, hi_corner_y, hi_corner_z, input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    lo_corner_x, lo_corner_y, lo_corner_z,
                    hi_corner_x, hi_corner_y, hi_corner_z, output ready);
endinterface

// Result channel.
interface rbsi_res_if;
    logic             valid;
    logic             ready;
    logic             hit;
    rbsi_pkg::t_coord distance;

    modport source (output valid, hit, distance, input ready);
    modport sink   (input valid, hit, distance, output ready);
endinterface

// Configuration write channel for min_distance.
interface rbsi_cfg_if;
    logic            valid;
    logic            ready;
    rbsi_pkg::t_mind min_distance;

    modport source (output valid, min_distance, input ready);
    modport sink   (input valid, min_distance, output ready);
endinterface

// File: rtl/rbsi_div.sv
// Pipelined restoring divider: one quotient bit per stage, unsigned magnitudes.
module rbsi_div (
    input  logic             i_clk,
    input  logic             i_en,
    input  rbsi_pkg::t_num   i_num,
    input  rbsi_pkg::t_den   i_den,
    output rbsi_pkg::t_num   o_quo
);

    localparam int NUM_W = rbsi_pkg::NUM_W;
    localparam int DEN_W = rbsi_pkg::DEN_W;

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++) begin : g_stage
            logic [DEN_W-1:0] src_rem;
            logic [NUM_W-1:0] src_nq;
            logic [DEN_W-1:0] src_den;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             qbit;
            logic [DEN_W-1:0] n_rem;
            logic [NUM_W-1:0] n_nq;

            if (k == 0) begin : g_first
                assign src_rem = '0;
                assign src_nq  = i_num;
                assign src_den = i_den;
            end else begin : g_next
                assign src_rem = r_rem[k-1];
                assign src_nq  = r_nq[k-1];
                assign src_den = r_den[k-1];
            end

            // Bring down the next numerator bit and try a subtraction.
            assign trial = {src_rem, src_nq[NUM_W-1]};
            assign diff  = trial - {1'b0, src_den};
            assign qbit  = ~diff[DEN_W];
            assign n_rem = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            // Numerator bits leave at the top while quotient bits enter at the bottom.
            assign n_nq  = {src_nq[NUM_W-2:0], qbit};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_nq[k]  <= n_nq;
                    r_den[k] <= src_den;
                end
            end
        end
    endgenerate

    assign o_quo = r_nq[NUM_W-1];

endmodule

// File: rtl/rbsi_interval.sv
// Saturation, slab ordering, interval narrowing and result selection.
module rbsi_interval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  rbsi_pkg::t_num    i_quo [rbsi_pkg::DIVS],
    input  rbsi_pkg::t_sb     i_sb,
    input  rbsi_pkg::t_mind   i_min_dist,
    output logic              o_valid,
    output logic              o_hit,
    output rbsi_pkg::t_coord  o_distance
);

    localparam int DIVS = rbsi_pkg::DIVS;
    localparam int AXES = rbsi_pkg::AXES;
    localparam int CW   = rbsi_pkg::COORD_WIDTH;
    localparam int T_W  = rbsi_pkg::T_W;
    localparam int MD_W = rbsi_pkg::MD_W;

    rbsi_pkg::t_coord r_s_val [DIVS];
    rbsi_pkg::t_coord n_s_val [DIVS];
    rbsi_pkg::t_sb    r_s_sb;

    rbsi_pkg::t_tval  r_c_lo, n_c_lo;
    rbsi_pkg::t_tval  r_c_hi, n_c_hi;
    logic             r_c_ok, n_c_ok;
    logic             r_c_vld;

    logic             n_hit;
    rbsi_pkg::t_coord n_dist;

    // Signed, saturated quotients from the unsigned magnitudes.
    always_comb begin
        rbsi_pkg::t_num negm;
        for (int j = 0; j < DIVS; j++) begin
            negm = '0 - i_quo[j];
            if (i_sb.neg[j]) begin
                n_s_val[j] = (i_quo[j] > rbsi_pkg::SAT_NEG) ? rbsi_pkg::COORD_MIN
                                                            : negm[CW-1:0];
            end else begin
                n_s_val[j] = (i_quo[j] > rbsi_pkg::SAT_POS) ? rbsi_pkg::COORD_MAX
                                                            : i_quo[j][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_sb <= '0;
        end else if (i_en) begin
            r_s_sb <= i_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s_val <= n_s_val;
        end
    end

    // Order each slab and narrow the interval over the bounded axes.
    always_comb begin
        rbsi_pkg::t_tval a;
        rbsi_pkg::t_tval b;
        rbsi_pkg::t_tval mn;
        rbsi_pkg::t_tval mx;
        n_c_lo = rbsi_pkg::T_LO_UNB;
        n_c_hi = rbsi_pkg::T_HI_UNB;
        n_c_ok = 1'b1;
        for (int ax = 0; ax < AXES; ax++) begin
            a  = {r_s_val[2*ax][CW-1], r_s_val[2*ax]};
            b  = {r_s_val[2*ax+1][CW-1], r_s_val[2*ax+1]};
            mn = (a > b) ? b : a;
            mx = (a > b) ? a : b;
            if (r_s_sb.zero[ax]) begin
                if (!r_s_sb.in_slab[ax]) begin
                    n_c_ok = 1'b0;
                end
            end else begin
                if (mn > n_c_lo) begin
                    n_c_lo = mn;
                end
                if (mx < n_c_hi) begin
                    n_c_hi = mx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_s_sb.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_lo <= n_c_lo;
            r_c_hi <= n_c_hi;
            r_c_ok <= n_c_ok;
        end
    end

    // Pick the near end, else the far end, past the minimum distance.
    always_comb begin
        rbsi_pkg::t_tval md;
        md     = {{(T_W-MD_W){1'b0}}, i_min_dist};
        n_hit  = 1'b0;
        n_dist = rbsi_pkg::MISS_DIST;
        if (r_c_ok && (r_c_lo <= r_c_hi)) begin
            if (r_c_lo > md) begin
                n_hit  = 1'b1;
                n_dist = r_c_lo[CW-1:0];
            end else if (r_c_hi > md) begin
                n_hit  = 1'b1;
                n_dist = (r_c_hi > {1'b0, rbsi_pkg::COORD_MAX}) ? rbsi_pkg::COORD_MAX
                                                                 : r_c_hi[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit      <= n_hit;
            o_distance <= n_dist;
        end
    end

endmodule

// File: rtl/ray_box_slab_intersect.sv
// Channel   Dir  Transaction
// i_ray     in   one ray origin, direction and box corners (12 x signed Q16.16)
// o_res     out  hit flag and hit distance (signed Q16.16, -1.0 on a miss)
// i_cfg     in   new min_distance (17-bit unsigned Q1.16), always ready
//
// One ray-box test (Q16.16) enters per cycle unless a waiting result stalls the
// pipeline; it passes the one-bit-per-stage dividers, six of them side by side.
// Synchronous active-low reset clears all valid bits and sets min_distance to 66.
// A result that is not taken stalls the whole pipeline in place; the input
// stays ready while the output register is empty or being taken.
module ray_box_slab_intersect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rbsi_ray_if.sink    i_ray,
    rbsi_res_if.source  o_res,
    rbsi_cfg_if.sink    i_cfg
);

    localparam int AXES  = rbsi_pkg::AXES;
    localparam int DIVS  = rbsi_pkg::DIVS;
    localparam int NUM_W = rbsi_pkg::NUM_W;
    localparam int CW    = rbsi_pkg::COORD_WIDTH;
    localparam int FB    = rbsi_pkg::FRAC_BITS;
    localparam int DW    = CW + 1;

    logic             en;
    rbsi_pkg::t_mind  r_min_dist;

    rbsi_pkg::t_coord org [AXES];
    rbsi_pkg::t_coord dir [AXES];
    rbsi_pkg::t_coord lo  [AXES];
    rbsi_pkg::t_coord hi  [AXES];

    rbsi_pkg::t_num   n_a_num [DIVS];
    rbsi_pkg::t_num   r_a_num [DIVS];
    rbsi_pkg::t_den   n_a_den [AXES];
    rbsi_pkg::t_den   r_a_den [AXES];
    rbsi_pkg::t_sb    n_a_sb;
    rbsi_pkg::t_sb    r_a_sb;
    rbsi_pkg::t_sb    r_sb [NUM_W];

    rbsi_pkg::t_num   quo [DIVS];
    logic             out_vld;

    // The pipeline moves unless a finished result waits at the output.
    assign en          = ~out_vld | o_res.ready;
    assign i_ray.ready = en;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist <= rbsi_pkg::MD_RESET;
        end else if (i_cfg.valid) begin
            r_min_dist <= i_cfg.min_distance;
        end
    end

    assign org = '{i_ray.origin_x, i_ray.origin_y, i_ray.origin_z};
    assign dir = '{i_ray.dir_x, i_ray.dir_y, i_ray.dir_z};
    assign lo  = '{i_ray.lo_corner_x, i_ray.lo_corner_y, i_ray.lo_corner_z};
    assign hi  = '{i_ray.hi_corner_x, i_ray.hi_corner_y, i_ray.hi_corner_z};

    // Slab distances as sign and magnitude, plus the zero-direction checks.
    always_comb begin
        logic signed [DW-1:0] dlo;
        logic signed [DW-1:0] dhi;
        logic        [DW-1:0] mlo;
        logic        [DW-1:0] mhi;
        logic        [CW-1:0] mden;
        n_a_sb.valid = i_ray.valid;
        for (int ax = 0; ax < AXES; ax++) begin
            dlo  = {lo[ax][CW-1], lo[ax]} - {org[ax][CW-1], org[ax]};
            dhi  = {hi[ax][CW-1], hi[ax]} - {org[ax][CW-1], org[ax]};
            mlo  = dlo[DW-1] ? DW'(-dlo) : DW'(dlo);
            mhi  = dhi[DW-1] ? DW'(-dhi) : DW'(dhi);
            mden = dir[ax][CW-1] ? CW'(-dir[ax]) : CW'(dir[ax]);
            n_a_num[2*ax]        = {mlo, {FB{1'b0}}};
            n_a_num[2*ax+1]      = {mhi, {FB{1'b0}}};
            n_a_den[ax]          = mden;
            n_a_sb.neg[2*ax]     = dlo[DW-1] ^ dir[ax][CW-1];
            n_a_sb.neg[2*ax+1]   = dhi[DW-1] ^ dir[ax][CW-1];
            n_a_sb.zero[ax]      = (dir[ax] == '0);
            n_a_sb.in_slab[ax]   = (org[ax] >= lo[ax]) && (org[ax] <= hi[ax]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_sb <= '0;
        end else if (en) begin
            r_a_sb <= n_a_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_num <= n_a_num;
            r_a_den <= n_a_den;
        end
    end

    // Control line that keeps step with the divider stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_sb[k] <= '0;
            end
        end else if (en) begin
            r_sb[0] <= r_a_sb;
            for (int k = 1; k < NUM_W; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    genvar j;
    generate
        for (j = 0; j < DIVS; j++) begin : g_div
            rbsi_div u_div (
                .i_clk (i_clk),
                .i_en  (en),
                .i_num (r_a_num[j]),
                .i_den (r_a_den[j/2]),
                .o_quo (quo[j])
            );
        end
    endgenerate

    rbsi_interval u_interval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_quo      (quo),
        .i_sb       (r_sb[NUM_W-1]),
        .i_min_dist (r_min_dist),
        .o_valid    (out_vld),
        .o_hit      (o_res.hit),
        .o_distance (o_res.distance)
    );

endmodule
